/* src/vt4x4_pkg.sv */
// Package for the 4x4 vertex transform: request types, field widths and defaults.
// Used by vertex_transform_4x4; depends on nothing else.
`default_nettype none

package vt4x4_pkg;

    localparam int FIELD_W        = 32;
    localparam int COEF_REG_W     = 64;
    localparam int NUM_ROWS       = 4;
    localparam int NUM_COLS       = 4;
    localparam int NUM_COEF_REGS  = 8;
    localparam int COEF_IDX_W     = $clog2(NUM_COEF_REGS);
    localparam int CFG_IDX_W      = 4;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_R0_C01,
        REG_R0_C23,
        REG_R1_C01,
        REG_R1_C23,
        REG_R2_C01,
        REG_R2_C23,
        REG_R3_C01,
        REG_R3_C23
    } t_coef_reg;

    typedef struct packed {
        logic signed [FIELD_W-1:0] in_x;
        logic signed [FIELD_W-1:0] in_y;
        logic signed [FIELD_W-1:0] in_z;
        logic signed [FIELD_W-1:0] in_w;
    } t_vertex_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic signed [FIELD_W-1:0] out_z;
        logic signed [FIELD_W-1:0] out_w;
        logic                      saturated;
    } t_vertex_out;

endpackage

`default_nettype wire

/* src/vertex_transform_4x4.sv */
// Top level of the 4x4 vertex transform: coefficient registers and the
// four-stage multiply, add, round and saturate pipeline. Depends on vt4x4_pkg.
`default_nettype none

// The block multiplies a configured 4x4 signed fixed-point matrix by one
// homogeneous vertex per request and returns the rounded, saturated result.
// It accepts one request per clock while backpressure does not stall it, and
// carries each result through four register stages: the sixteen multipliers,
// which load at the accepting edge, the pair sums, the row sums with the
// rounding constant, and the output register after saturation. Backpressure
// stalls only the stages that are full, and reset loads the identity matrix.
module vertex_transform_4x4 #(
    parameter int DATA_WIDTH = vt4x4_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = vt4x4_pkg::FRAC_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  vt4x4_pkg::t_vertex_in              i_in_data,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output vt4x4_pkg::t_vertex_out             o_out_data,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [vt4x4_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [vt4x4_pkg::COEF_REG_W-1:0]    i_cfg_data
);
    import vt4x4_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;
    localparam int AW = PW + 1;
    localparam int SW = PW + 2;
    localparam int RW = SW - FRAC_BITS;
    localparam int HALF_W = COEF_REG_W / 2;

    localparam logic [COEF_REG_W-1:0] COEF_ONE_LO = COEF_REG_W'(1) << FRAC_BITS;
    localparam logic [COEF_REG_W-1:0] COEF_ONE_HI = COEF_ONE_LO << HALF_W;
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) << (FRAC_BITS - 1);
    localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [COEF_REG_W-1:0]        r_coef [NUM_COEF_REGS];
    logic signed [DATA_WIDTH-1:0] coef   [NUM_ROWS][NUM_COLS];
    logic signed [DATA_WIDTH-1:0] vin    [NUM_COLS];

    logic [3:0]                   r_vld;
    logic                         en0, en1, en2, en3;

    logic signed [PW-1:0]         r_prod [NUM_ROWS][NUM_COLS];
    logic signed [AW-1:0]         r_pair [NUM_ROWS][2];
    logic signed [SW-1:0]         r_sum  [NUM_ROWS];

    logic signed [RW-1:0]         shifted [NUM_ROWS];
    logic signed [DATA_WIDTH-1:0] sres    [NUM_ROWS];
    logic [NUM_ROWS-1:0]          sat;
    t_vertex_out                  n_out;
    t_vertex_out                  r_out;

    // Coefficient registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF_REGS; i++) begin
                case (CFG_IDX_W'(i))
                    REG_R0_C01, REG_R2_C23: begin
                        r_coef[COEF_IDX_W'(i)] <= COEF_ONE_LO;
                    end
                    REG_R1_C01, REG_R3_C23: begin
                        r_coef[COEF_IDX_W'(i)] <= COEF_ONE_HI;
                    end
                    default: begin
                        r_coef[COEF_IDX_W'(i)] <= '0;
                    end
                endcase
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_COEF_REGS))) begin
            r_coef[i_cfg_index[COEF_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_coef_row
        for (genvar c = 0; c < NUM_COLS; c++) begin : g_coef_col
            localparam int RI = r * 2 + c / 2;
            localparam int LO = (c % 2) * HALF_W;
            assign coef[r][c] = $signed(r_coef[RI][LO +: DATA_WIDTH]);
        end
    end

    assign vin[0] = $signed(i_in_data.in_x[DATA_WIDTH-1:0]);
    assign vin[1] = $signed(i_in_data.in_y[DATA_WIDTH-1:0]);
    assign vin[2] = $signed(i_in_data.in_z[DATA_WIDTH-1:0]);
    assign vin[3] = $signed(i_in_data.in_w[DATA_WIDTH-1:0]);

    // Stage enables: a stage moves when it is empty or the next one moves.
    assign en3 = !r_vld[3] || i_out_ready;
    assign en2 = !r_vld[2] || en3;
    assign en1 = !r_vld[1] || en2;
    assign en0 = !r_vld[0] || en1;
    assign o_in_ready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en0) begin
                r_vld[0] <= i_in_valid;
            end
            if (en1) begin
                r_vld[1] <= r_vld[0];
            end
            if (en2) begin
                r_vld[2] <= r_vld[1];
            end
            if (en3) begin
                r_vld[3] <= r_vld[2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int c = 0; c < NUM_COLS; c++) begin
                    r_prod[r][c] <= PW'(coef[r][c]) * PW'(vin[c]);
                end
            end
        end
        if (en1) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_pair[r][0] <= AW'(r_prod[r][0]) + AW'(r_prod[r][1]);
                r_pair[r][1] <= AW'(r_prod[r][2]) + AW'(r_prod[r][3]);
            end
        end
        if (en2) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_sum[r] <= SW'(r_pair[r][0]) + SW'(r_pair[r][1]) + ROUND_HALF;
            end
        end
        if (en3) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            shifted[r] = $signed(r_sum[r][SW-1:FRAC_BITS]);
            sat[r] = !((&shifted[r][RW-1:DATA_WIDTH-1]) || !(|shifted[r][RW-1:DATA_WIDTH-1]));
            if (sat[r]) begin
                sres[r] = shifted[r][RW-1] ? MINV : MAXV;
            end else begin
                sres[r] = shifted[r][DATA_WIDTH-1:0];
            end
        end
        n_out.out_x     = FIELD_W'(sres[0]);
        n_out.out_y     = FIELD_W'(sres[1]);
        n_out.out_z     = FIELD_W'(sres[2]);
        n_out.out_w     = FIELD_W'(sres[3]);
        n_out.saturated = |sat;
    end

    assign o_out_valid = r_vld[3];
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
